[rtl/bpa_pkg.sv]
package bpa_pkg;

	localparam int PAGE_COUNT_DEF = 4096;
	localparam int MAX_ORDER_DEF  = 4;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_ALLOCATED   = 3'd0;
	localparam logic [2:0] ST_FREED       = 3'd1;
	localparam logic [2:0] ST_ALREADY     = 3'd2;
	localparam logic [2:0] ST_NO_BLOCK    = 3'd3;
	localparam logic [2:0] ST_BAD_ORDER   = 3'd4;

	// per-page status codes
	localparam logic [1:0] PG_RESERVED = 2'd0;
	localparam logic [1:0] PG_FREE     = 2'd1;
	localparam logic [1:0] PG_ALLOC    = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  order;
		logic [11:0] page_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] block_index;
		logic [2:0]  block_order;
	} rsp_t;

endpackage

[rtl/buddy_page_allocator.sv]
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | bpa_pkg::req_t (req_type, order, page_index)
// rsp     | out       | rsp_valid / rsp_ready | bpa_pkg::rsp_t (status, block_index, block_order)
//
// After reset a clearing pass writes every page entry once, with req_ready low.
// One request at a time; all page state sits in one single-port-per-direction RAM, so every
// link update is a read followed by a write back. A bad order goes straight to the result; an
// allocate searches the levels upward, unlinks the block found and splits it level by level;
// a free merges with buddies level by level and ends with a push onto a free list.
// A waiting result holds in the output register; the next request is taken meanwhile and
// its result waits until the register drains.
module buddy_page_allocator #(
	parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
	parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bpa_pkg::rsp_t rsp
);

	import bpa_pkg::*;

	localparam int AW  = $clog2(PAGE_COUNT);
	localparam int LKW = $clog2(PAGE_COUNT + 1);
	localparam int LW  = $clog2(MAX_ORDER + 2);
	localparam int HW  = $clog2(MAX_ORDER + 1);
	localparam int SW  = ((AW > MAX_ORDER) ? AW : MAX_ORDER) + 1;

	localparam logic [LKW-1:0] LINK_NULL  = LKW'(PAGE_COUNT);
	localparam logic [LW-1:0]  LEVEL_NONE = '1;
	localparam logic [LW-1:0]  LEVEL_MAX  = LW'(MAX_ORDER);
	localparam logic [SW-1:0]  PAGE_LIM   = SW'(PAGE_COUNT);

	typedef struct packed {
		logic [1:0]     st;
		logic [LW-1:0]  lv;
		logic [LKW-1:0] nx;
		logic [LKW-1:0] pv;
	} ent_t;

	localparam int EW = $bits(ent_t);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_CHK   = 5'd2;
	localparam logic [4:0] S_SRCH  = 5'd3;
	localparam logic [4:0] S_A_RD  = 5'd4;
	localparam logic [4:0] S_A_MRK = 5'd5;
	localparam logic [4:0] S_A_SPL = 5'd6;
	localparam logic [4:0] S_F_RD  = 5'd7;
	localparam logic [4:0] S_F_BUD = 5'd8;
	localparam logic [4:0] S_F_CHK = 5'd9;
	localparam logic [4:0] S_F_MRG = 5'd10;
	localparam logic [4:0] S_F_END = 5'd11;
	localparam logic [4:0] S_FIN   = 5'd12;
	localparam logic [4:0] S_P0    = 5'd13;
	localparam logic [4:0] S_P1    = 5'd14;
	localparam logic [4:0] S_P2    = 5'd15;
	localparam logic [4:0] S_P3    = 5'd16;
	localparam logic [4:0] S_P4    = 5'd17;
	localparam logic [4:0] S_U0    = 5'd18;
	localparam logic [4:0] S_U1    = 5'd19;
	localparam logic [4:0] S_U2    = 5'd20;
	localparam logic [4:0] S_U3    = 5'd21;
	localparam logic [4:0] S_U4    = 5'd22;

	logic [4:0]     state_q;
	logic [4:0]     ret_u_q;
	logic [4:0]     ret_p_q;
	logic [AW-1:0]  clr_q;
	req_t           req_q;
	logic [LW-1:0]  cur_q;
	logic [AW-1:0]  pg_q;
	logic [AW-1:0]  h_pg_q;
	logic [LW-1:0]  h_lv_q;
	logic [AW-1:0]  u_pg_q;
	ent_t           u_e_q;
	logic [LKW-1:0] nx_q;
	logic [LKW-1:0] head_q [MAX_ORDER+1];
	rsp_t           res_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	ent_t          ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rbits;
	ent_t          rd;

	logic [LKW-1:0] hd_cur;
	logic [LKW-1:0] hd_h;
	logic [LKW-1:0] hd_u;
	logic [LW-1:0]  cur_dec;
	logic [SW-1:0]  half_w;
	logic [SW-1:0]  bud_w;
	logic           idx_out;
	logic           u_listed;
	logic           rd_listed;

	bpa_ram #(
		.WIDTH(EW),
		.DEPTH(PAGE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rbits)
	);

	assign rd = ent_t'(ram_rbits);

	// address and list helpers
	assign hd_cur    = head_q[cur_q[HW-1:0]];
	assign hd_h      = head_q[h_lv_q[HW-1:0]];
	assign hd_u      = head_q[u_e_q.lv[HW-1:0]];
	assign cur_dec   = cur_q - LW'(1);
	assign half_w    = SW'(pg_q) + (SW'(1) << cur_dec);
	assign bud_w     = SW'(pg_q) ^ (SW'(1) << cur_q);
	assign idx_out   = 32'(req_q.page_index) >= PAGE_COUNT;
	assign u_listed  = u_e_q.lv <= LEVEL_MAX;
	assign rd_listed = (rd.st == PG_FREE) && (rd.lv <= LEVEL_MAX);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// drive the RAM ports from the sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pg_q;
		ram_wdata = '{st: PG_RESERVED, lv: LEVEL_NONE, nx: LINK_NULL, pv: LINK_NULL};
		ram_re    = 1'b0;
		ram_raddr = pg_q;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_CHK: begin
				if (32'(req_q.order) <= MAX_ORDER && req_q.req_type == REQ_FREE && !idx_out) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(req_q.page_index);
				end
			end
			S_SRCH: begin
				if (cur_q <= LEVEL_MAX && hd_cur < LINK_NULL) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(hd_cur);
				end
			end
			S_A_MRK: begin
				ram_we    = 1'b1;
				ram_wdata = '{st: PG_ALLOC, lv: LW'(req_q.order), nx: LINK_NULL, pv: LINK_NULL};
			end
			S_F_RD: begin
				if (rd.st != PG_FREE) begin
					ram_we    = 1'b1;
					ram_wdata = '{st: PG_FREE, lv: LEVEL_NONE, nx: rd.nx, pv: rd.pv};
				end
			end
			S_F_BUD: begin
				if (cur_q < LEVEL_MAX && bud_w < PAGE_LIM) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(bud_w);
				end
			end
			S_P0: begin
				ram_re    = 1'b1;
				ram_raddr = h_pg_q;
			end
			S_P2: begin
				ram_we    = 1'b1;
				ram_waddr = h_pg_q;
				ram_wdata = '{st: PG_FREE, lv: h_lv_q, nx: hd_h, pv: LINK_NULL};
			end
			S_P3: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(nx_q);
			end
			S_P4: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(nx_q);
				ram_wdata = '{st: rd.st, lv: rd.lv, nx: rd.nx, pv: LKW'(h_pg_q)};
			end
			S_U0: begin
				if (u_listed && u_e_q.pv < LINK_NULL) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(u_e_q.pv);
				end
			end
			S_U1: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(u_e_q.pv);
				ram_wdata = '{st: rd.st, lv: rd.lv, nx: u_e_q.nx, pv: rd.pv};
			end
			S_U2: begin
				if (u_e_q.nx < LINK_NULL) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(u_e_q.nx);
				end
			end
			S_U3: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(u_e_q.nx);
				ram_wdata = '{st: rd.st, lv: rd.lv, nx: rd.nx, pv: u_e_q.pv};
			end
			S_U4: begin
				ram_we    = 1'b1;
				ram_waddr = u_pg_q;
				ram_wdata = '{st: u_e_q.st, lv: LEVEL_NONE, nx: LINK_NULL, pv: LINK_NULL};
			end
			default: begin
			end
		endcase
	end

	// sequencer: request decode, search, split, merge and list subroutines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_u_q     <= S_IDLE;
			ret_p_q     <= S_IDLE;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i <= MAX_ORDER; i++) begin
				head_q[i] <= LINK_NULL;
			end
		end else begin
			// drop the result once taken, unless a new one is loaded now
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(PAGE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (32'(req_q.order) > MAX_ORDER) begin
						res_q   <= '{status: ST_BAD_ORDER, block_index: '0, block_order: '0};
						state_q <= S_FIN;
					end else if (req_q.req_type == REQ_ALLOC) begin
						cur_q   <= LW'(req_q.order);
						state_q <= S_SRCH;
					end else if (idx_out) begin
						res_q   <= '{status: ST_NO_BLOCK, block_index: '0, block_order: '0};
						state_q <= S_FIN;
					end else begin
						pg_q    <= AW'(req_q.page_index);
						state_q <= S_F_RD;
					end
				end
				S_SRCH: begin
					if (cur_q > LEVEL_MAX) begin
						res_q   <= '{status: ST_NO_BLOCK, block_index: '0,
							block_order: req_q.order};
						state_q <= S_FIN;
					end else if (hd_cur < LINK_NULL) begin
						pg_q    <= AW'(hd_cur);
						state_q <= S_A_RD;
					end else begin
						cur_q <= cur_q + LW'(1);
					end
				end
				S_A_RD: begin
					u_pg_q  <= pg_q;
					u_e_q   <= rd;
					ret_u_q <= S_A_MRK;
					state_q <= S_U0;
				end
				S_A_MRK: begin
					state_q <= S_A_SPL;
				end
				S_A_SPL: begin
					if (cur_q == LW'(req_q.order)) begin
						res_q   <= '{status: ST_ALLOCATED, block_index: 12'(pg_q),
							block_order: req_q.order};
						state_q <= S_FIN;
					end else begin
						cur_q <= cur_dec;
						if (half_w < PAGE_LIM) begin
							h_pg_q  <= AW'(half_w);
							h_lv_q  <= cur_dec;
							ret_p_q <= S_A_SPL;
							state_q <= S_P0;
						end
					end
				end
				S_F_RD: begin
					if (rd.st == PG_FREE) begin
						res_q   <= '{status: ST_ALREADY, block_index: req_q.page_index,
							block_order: req_q.order};
						state_q <= S_FIN;
					end else begin
						cur_q   <= LW'(req_q.order);
						state_q <= S_F_BUD;
					end
				end
				S_F_BUD: begin
					if (cur_q < LEVEL_MAX && bud_w < PAGE_LIM) begin
						state_q <= S_F_CHK;
					end else begin
						h_pg_q  <= pg_q;
						h_lv_q  <= cur_q;
						ret_p_q <= S_F_END;
						state_q <= S_P0;
					end
				end
				S_F_CHK: begin
					if (rd.st == PG_FREE && rd.lv == cur_q) begin
						u_pg_q  <= AW'(bud_w);
						u_e_q   <= rd;
						ret_u_q <= S_F_MRG;
						state_q <= S_U0;
					end else begin
						h_pg_q  <= pg_q;
						h_lv_q  <= cur_q;
						ret_p_q <= S_F_END;
						state_q <= S_P0;
					end
				end
				S_F_MRG: begin
					pg_q    <= pg_q & AW'(bud_w);
					cur_q   <= cur_q + LW'(1);
					state_q <= S_F_BUD;
				end
				S_F_END: begin
					res_q   <= '{status: ST_FREED, block_index: 12'(pg_q), block_order: 3'(cur_q)};
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				// push: unlink if listed, then link at the head
				S_P0: begin
					state_q <= S_P1;
				end
				S_P1: begin
					if (rd_listed) begin
						u_pg_q  <= h_pg_q;
						u_e_q   <= rd;
						ret_u_q <= S_P2;
						state_q <= S_U0;
					end else begin
						state_q <= S_P2;
					end
				end
				S_P2: begin
					nx_q                    <= hd_h;
					head_q[h_lv_q[HW-1:0]] <= LKW'(h_pg_q);
					state_q                 <= (hd_h < LINK_NULL) ? S_P3 : ret_p_q;
				end
				S_P3: begin
					state_q <= S_P4;
				end
				S_P4: begin
					state_q <= ret_p_q;
				end
				// unlink: patch neighbors or the list head
				S_U0: begin
					if (!u_listed) begin
						state_q <= ret_u_q;
					end else if (u_e_q.pv < LINK_NULL) begin
						state_q <= S_U1;
					end else begin
						if (hd_u == LKW'(u_pg_q)) begin
							head_q[u_e_q.lv[HW-1:0]] <= u_e_q.nx;
						end
						state_q <= S_U2;
					end
				end
				S_U1: begin
					state_q <= S_U2;
				end
				S_U2: begin
					state_q <= (u_e_q.nx < LINK_NULL) ? S_U3 : S_U4;
				end
				S_U3: begin
					state_q <= S_U4;
				end
				S_U4: begin
					state_q <= ret_u_q;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("RAM read and write issued together");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_CHK))
		else $error("accepted transaction not decoded");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q[0] <= LINK_NULL)
		else $error("list head out of range");
`endif

endmodule

[rtl/bpa_ram.sv]
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
